@@ rtl/core/rms_record_deframer_defines.svh @@
// ----------------------------------------------------------------------------
// rms_record_deframer_defines.svh
// assertion macros for the record deframer checker
// ----------------------------------------------------------------------------
`ifndef RMS_RECORD_DEFRAMER_DEFINES_SVH
`define RMS_RECORD_DEFRAMER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define RRD_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("record deframer check failed");

// next-cycle implication, checked outside reset
`define RRD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("record deframer check failed");

`endif

@@ rtl/core/rrd_pkg.sv @@
// ----------------------------------------------------------------------------
// rrd_pkg
// types and codes shared by the record deframer modules
// ----------------------------------------------------------------------------
package rrd_pkg;

    // record format codes
    localparam logic [2:0] FMT_UNDEF     = 3'd0;
    localparam logic [2:0] FMT_FIXED     = 3'd1;
    localparam logic [2:0] FMT_VARIABLE  = 3'd2;
    localparam logic [2:0] FMT_VFC       = 3'd3;
    localparam logic [2:0] FMT_STREAM    = 3'd4;
    localparam logic [2:0] FMT_STREAM_LF = 3'd5;
    localparam logic [2:0] FMT_STREAM_CR = 3'd6;
    localparam logic [2:0] FMT_NONE      = 3'd7;

    // configuration register indexes
    localparam logic [1:0] CFG_RECORD_FORMAT = 2'd0;
    localparam logic [1:0] CFG_CONTROL_SIZE  = 2'd1;
    localparam logic [1:0] CFG_FILE_LENGTH   = 2'd2;
    localparam logic [1:0] CFG_NO_NEWLINE    = 2'd3;

    // record length phases
    localparam logic [1:0] PH_LEN_LO = 2'd0;
    localparam logic [1:0] PH_LEN_HI = 2'd1;
    localparam logic [1:0] PH_DATA   = 2'd2;

    // character codes
    localparam logic [7:0] CHAR_CR = 8'd13;
    localparam logic [7:0] CHAR_LF = 8'd10;

    // default control field size for vfc records
    localparam logic [7:0] VFC_DEFAULT_CTL = 8'd2;

    // result queue depth
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic       has_byte;
        logic [7:0] out_byte;
        logic       last_of_run;
        logic       bad_format;
        logic       end_of_block;
    } t_result;

    // up to two results from one decoded request
    typedef struct packed {
        logic [1:0] count;
        t_result    res0;
        t_result    res1;
    } t_push;

    typedef struct packed {
        logic [2:0]  record_format;
        logic [7:0]  control_size;
        logic [31:0] file_length;
        logic        no_newline;
    } t_cfg;

endpackage

@@ rtl/core/rrd_core.sv @@
// ----------------------------------------------------------------------------
// rrd_core
// input register, record decode state and per-byte decode logic
// ----------------------------------------------------------------------------
module rrd_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  logic           i_mode,
    input  logic [7:0]     i_data_byte,
    input  logic           i_block_last,
    input  rrd_pkg::t_cfg  i_cfg,
    input  logic           i_room,
    output rrd_pkg::t_push o_push
);

    logic        r_in_valid;
    logic        r_mode;
    logic [7:0]  r_byte;
    logic        r_blast;

    logic [31:0] r_consumed, n_consumed;
    logic [15:0] r_record_left, n_record_left;
    logic [1:0]  r_phase, n_phase;
    logic [7:0]  r_length_low, n_length_low;
    logic [8:0]  r_skip_left, n_skip_left;
    logic        r_fault, n_fault;

    logic           fire;
    logic           in_accept;
    logic [31:0]    pos;
    logic [7:0]     ctl_size;
    logic [15:0]    len;
    logic [15:0]    rec_len;
    logic [8:0]     skip_val;
    logic [15:0]    left_dec;
    rrd_pkg::t_push push;

    assign fire       = r_in_valid && i_room;
    assign in_accept  = i_in_valid && o_in_ready;
    assign o_in_ready = !r_in_valid || fire;
    assign o_push     = push;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_mode  <= i_mode;
            r_byte  <= i_data_byte;
            r_blast <= i_block_last;
        end
    end

    // decode state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_consumed    <= '0;
            r_record_left <= '0;
            r_phase       <= rrd_pkg::PH_LEN_LO;
            r_length_low  <= '0;
            r_skip_left   <= '0;
            r_fault       <= 1'b0;
        end else begin
            r_consumed    <= n_consumed;
            r_record_left <= n_record_left;
            r_phase       <= n_phase;
            r_length_low  <= n_length_low;
            r_skip_left   <= n_skip_left;
            r_fault       <= n_fault;
        end
    end

    // record length arithmetic
    assign pos      = r_consumed + 32'd1;
    assign ctl_size = (i_cfg.control_size == 8'd0) ? rrd_pkg::VFC_DEFAULT_CTL
                                                   : i_cfg.control_size;
    assign len      = {r_byte, r_length_low};
    assign left_dec = r_record_left - 16'd1;

    always_comb begin
        rec_len  = len;
        skip_val = 9'd0;
        if (i_cfg.record_format == rrd_pkg::FMT_VFC) begin
            skip_val = {1'b0, ctl_size};
            rec_len  = (len > {8'd0, ctl_size}) ? (len - {8'd0, ctl_size}) : 16'd0;
        end
    end

    // per-byte decode
    always_comb begin
        n_consumed    = r_consumed;
        n_record_left = r_record_left;
        n_phase       = r_phase;
        n_length_low  = r_length_low;
        n_skip_left   = r_skip_left;
        n_fault       = r_fault;
        push          = '0;

        if (fire) begin
            if (r_mode) begin
                // new file clears everything
                n_consumed    = '0;
                n_record_left = '0;
                n_phase       = rrd_pkg::PH_LEN_LO;
                n_length_low  = '0;
                n_skip_left   = '0;
                n_fault       = 1'b0;
            end else if (r_fault || !(r_consumed < i_cfg.file_length)) begin
                // dropped byte
            end else if (i_cfg.record_format == rrd_pkg::FMT_UNDEF ||
                         i_cfg.record_format == rrd_pkg::FMT_NONE) begin
                n_fault              = 1'b1;
                push.res0.bad_format = 1'b1;
                push.count           = 2'd1;
            end else begin
                n_consumed = pos;
                unique case (i_cfg.record_format)
                    rrd_pkg::FMT_STREAM_CR: begin
                        push.res0.has_byte = 1'b1;
                        push.res0.out_byte = (r_byte == rrd_pkg::CHAR_CR) ? rrd_pkg::CHAR_LF
                                                                         : r_byte;
                        push.count         = 2'd1;
                    end
                    rrd_pkg::FMT_VARIABLE, rrd_pkg::FMT_VFC: begin
                        priority if (r_skip_left != 9'd0) begin
                            n_skip_left = r_skip_left - 9'd1;
                        end else if (r_phase == rrd_pkg::PH_LEN_LO) begin
                            n_length_low = r_byte;
                            n_phase      = rrd_pkg::PH_LEN_HI;
                        end else if (r_phase == rrd_pkg::PH_LEN_HI) begin
                            n_phase       = rrd_pkg::PH_DATA;
                            n_record_left = rec_len;
                            n_skip_left   = skip_val;
                            if (rec_len == 16'd0) begin
                                // record ends with its length field
                                n_phase     = rrd_pkg::PH_LEN_LO;
                                n_skip_left = skip_val + {8'd0, pos[0] ^ skip_val[0]};
                                if (!i_cfg.no_newline) begin
                                    push.res0.has_byte = 1'b1;
                                    push.res0.out_byte = rrd_pkg::CHAR_LF;
                                    push.count         = 2'd1;
                                end
                            end
                        end else begin
                            // record data, phase two or the spare code
                            push.res0.has_byte = 1'b1;
                            push.res0.out_byte = r_byte;
                            push.count         = 2'd1;
                            n_record_left      = left_dec;
                            if (left_dec == 16'd0) begin
                                n_phase     = rrd_pkg::PH_LEN_LO;
                                n_skip_left = {8'd0, pos[0]};
                                if (!i_cfg.no_newline) begin
                                    push.res1.has_byte = 1'b1;
                                    push.res1.out_byte = rrd_pkg::CHAR_LF;
                                    push.count         = 2'd2;
                                end
                            end
                        end
                    end
                    default: begin
                        push.res0.has_byte = 1'b1;
                        push.res0.out_byte = r_byte;
                        push.count         = 2'd1;
                    end
                endcase
            end

            // mark the final result of this request
            if (push.count == 2'd1) begin
                push.res0.last_of_run  = 1'b1;
                push.res0.end_of_block = r_blast;
            end else if (push.count == 2'd2) begin
                push.res1.last_of_run  = 1'b1;
                push.res1.end_of_block = r_blast;
            end
        end
    end

endmodule

@@ rtl/core/rrd_outq.sv @@
// ----------------------------------------------------------------------------
// rrd_outq
// small result queue taking up to two results per cycle, giving one per cycle while the receiver is ready
// ----------------------------------------------------------------------------
module rrd_outq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  rrd_pkg::t_push   i_push,
    output logic             o_room,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output rrd_pkg::t_result o_result
);

    localparam int AW = rrd_pkg::QUEUE_AW;

    rrd_pkg::t_result r_q [rrd_pkg::QUEUE_DEPTH];
    logic [AW-1:0]    r_wr, r_rd;
    logic [AW:0]      r_count;
    logic             pop;

    assign o_out_valid = (r_count != '0);
    assign pop         = o_out_valid && i_out_ready;
    assign o_result    = r_q[r_rd];
    // room for two more after this cycle's pop
    assign o_room      = (r_count <= (AW+1)'(rrd_pkg::QUEUE_DEPTH - 2)) ||
                         (pop && (r_count <= (AW+1)'(rrd_pkg::QUEUE_DEPTH - 1)));

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= r_wr + AW'(i_push.count);
            r_rd    <= r_rd + AW'(pop);
            r_count <= r_count + (AW+1)'(i_push.count) - (AW+1)'(pop);
        end
    end

    // result storage
    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_q[r_wr] <= i_push.res0;
        end
        if (i_push.count == 2'd2) begin
            r_q[r_wr + AW'(1)] <= i_push.res1;
        end
    end

endmodule

@@ rtl/core/rms_record_deframer.sv @@
// ----------------------------------------------------------------------------
// rms_record_deframer
// decodes the record format of saved file data, one byte per request
// ----------------------------------------------------------------------------
// Input channel i_in_valid/o_in_ready carries one request: a data byte, the
// new-file mode bit and the tape block-last flag. Output channel
// o_out_valid/i_out_ready carries results: a decoded byte or newline, the
// error flag, and last/end-of-block marks on the final result of a request.
// Configuration writes come on i_cfg_valid/o_cfg_ready (always ready) with a
// register index and data; write them only while the block is idle.
// An accepted request is held in the input register, decoded once the queue
// has room, and its results are written to the result queue for output.
// One request per cycle while the queue has room; a request that gives a
// byte plus a newline pushes two results, given one at a time by the
// single-result output port; a four-entry result queue absorbs the extra one.
// A stalled receiver fills the queue; input ready drops while a request
// waits and the queue, after this cycle's pop, has fewer than two free slots.
// Reset restores the register defaults (variable format, file length zero)
// and clears the decode state, input register and queue.
// ----------------------------------------------------------------------------
module rms_record_deframer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_mode,
    input  logic [7:0]  i_data_byte,
    input  logic        i_block_last,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_has_byte,
    output logic [7:0]  o_out_byte,
    output logic        o_last_of_run,
    output logic        o_bad_format,
    output logic        o_end_of_block,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    rrd_pkg::t_cfg    r_cfg;
    rrd_pkg::t_push   push;
    rrd_pkg::t_result result;
    logic             room;

    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.record_format <= rrd_pkg::FMT_VARIABLE;
            r_cfg.control_size  <= 8'd0;
            r_cfg.file_length   <= 32'd0;
            r_cfg.no_newline    <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                rrd_pkg::CFG_RECORD_FORMAT: r_cfg.record_format <= i_cfg_data[2:0];
                rrd_pkg::CFG_CONTROL_SIZE:  r_cfg.control_size  <= i_cfg_data[7:0];
                rrd_pkg::CFG_FILE_LENGTH:   r_cfg.file_length   <= i_cfg_data;
                rrd_pkg::CFG_NO_NEWLINE:    r_cfg.no_newline    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // decode stage
    rrd_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_mode       (i_mode),
        .i_data_byte  (i_data_byte),
        .i_block_last (i_block_last),
        .i_cfg        (r_cfg),
        .i_room       (room),
        .o_push       (push)
    );

    // result queue
    rrd_outq u_outq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_room      (room),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_result    (result)
    );

    assign o_has_byte     = result.has_byte;
    assign o_out_byte     = result.out_byte;
    assign o_last_of_run  = result.last_of_run;
    assign o_bad_format   = result.bad_format;
    assign o_end_of_block = result.end_of_block;

endmodule

@@ rtl/core/rrd_checker.sv @@
// ----------------------------------------------------------------------------
// rrd_checker
// port-level checks on the record deframer results
// ----------------------------------------------------------------------------
`include "rms_record_deframer_defines.svh"

module rrd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic        o_has_byte,
    input logic [7:0]  o_out_byte,
    input logic        o_last_of_run,
    input logic        o_bad_format,
    input logic        o_end_of_block
);

    // an error result carries no byte and closes its request
    `RRD_ASSERT_NOW(a_bad_alone, i_clk, i_rst_n, o_out_valid && o_bad_format, !o_has_byte && o_last_of_run)

    // a result with no byte shows a zero byte
    `RRD_ASSERT_NOW(a_empty_zero, i_clk, i_rst_n, o_out_valid && !o_has_byte, o_out_byte == 8'd0)

    // block end is reported only on the final result of a request
    `RRD_ASSERT_NOW(a_eob_last, i_clk, i_rst_n, o_out_valid && o_end_of_block, o_last_of_run)

    // a stalled result holds
    `RRD_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_byte) && $stable(o_last_of_run))

endmodule

bind rms_record_deframer rrd_checker u_rrd_checker (.*);
